// ===== rtl/odo_pkg.sv =====
// Shared types and constants for the differential odometry integrator.
// No dependencies; imported by odo_cordic, odo_mac and the top level.
package odo_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLR_X = 2'd2,
    CMD_CLR_Y = 2'd3
  } odo_cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_REV  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DEADBAND = 1'b1;

  localparam logic [31:0] DIST_PER_REV_RST  = 32'd65536;
  localparam logic [15:0] STEP_DEADBAND_RST = 16'd66;

  // Input and result items
  typedef struct packed {
    odo_cmd_t           cmd;
    logic        [15:0] heading_angle;
    logic signed [31:0] left_revs;
    logic signed [31:0] right_revs;
    logic signed [47:0] new_x;
    logic signed [47:0] new_y;
  } odo_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] left_distance;
    logic signed [47:0] right_distance;
  } odo_out_t;

  // Sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_TAKE,
    S_SUM,
    S_ABS,
    S_DONE
  } odo_state_t;

  typedef enum logic [1:0] {
    OP_LEFT,
    OP_RIGHT,
    OP_Y,
    OP_X
  } odo_op_t;

  // Multiply-accumulate control
  typedef struct packed {
    logic issue;    // launch a partial product this cycle
    logic first;    // partial product loads the accumulator
    logic rnd;      // add one half LSB of Q.16 on load
    logic shift32;  // later partial product weight: 2^32, else 2^16
  } odo_mac_ctl_t;

  localparam logic [63:0] ROUND_HALF = 64'd32768;

  // CORDIC
  localparam int XY_W       = 34;
  localparam int Z_W        = 33;
  localparam int ATAN_COUNT = 24;
  localparam int ATAN_IDX_W = 5;

  localparam logic signed [XY_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [15:0]     Q15_MAX      = 16'sd32767;

  localparam logic [31:0] ATAN_TURNS [ATAN_COUNT] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Sine/cosine result handed to the sequencer
  typedef struct packed {
    logic               done;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } odo_trig_t;

endpackage

// ===== rtl/odo_cordic.sv =====
// Iterative CORDIC sine/cosine, one rotation per cycle through one shifter pair.
// Depends on odo_pkg (arctangent table, widths, odo_trig_t).
module odo_cordic #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [15:0]       heading,
  output odo_pkg::odo_trig_t trig
);
  import odo_pkg::*;

  localparam int N_ITER = (TRIG_ITERATIONS > ATAN_COUNT) ? ATAN_COUNT : TRIG_ITERATIONS;
  localparam logic [ATAN_IDX_W-1:0] LAST_IT = ATAN_IDX_W'(N_ITER - 1);
  localparam logic [31:0] ANG_MASK = ~(32'hFFFF_FFFF >> ANGLE_BITS);

  logic                   busy;
  logic                   fin;
  logic [ATAN_IDX_W-1:0]  cnt;
  logic [1:0]             quad;
  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic                   done_q;
  logic signed [15:0]     cos_q;
  logic signed [15:0]     sin_q;

  logic [31:0]            ang;
  logic [31:0]            ang_rnd;
  logic [1:0]             quad_next;
  logic [31:0]            resid;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  at;
  logic signed [15:0]     c_q;
  logic signed [15:0]     s_q;

  function automatic logic signed [15:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    t = (v + XY_W'(16384)) >>> 15;
    if (t > XY_W'(Q15_MAX)) begin
      return Q15_MAX;
    end else if (t < -XY_W'(Q15_MAX)) begin
      return -Q15_MAX;
    end
    return t[15:0];
  endfunction

  assign trig = {done_q, cos_q, sin_q};

  // fold to the nearest quadrant
  always_comb begin
    ang       = {heading, 16'h0000} & ANG_MASK;
    ang_rnd   = ang + 32'h2000_0000;
    quad_next = ang_rnd[31:30];
    resid     = ang - {quad_next, 30'b0};
  end

  always_comb begin
    xs  = x >>> cnt;
    ys  = y >>> cnt;
    at  = $signed({1'b0, ATAN_TURNS[cnt]});
    c_q = to_q15(x);
    s_q = to_q15(y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      fin    <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      fin    <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST_IT) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end else if (fin) begin
      fin    <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad <= quad_next;
      x    <= CORDIC_START;
      y    <= '0;
      z    <= Z_W'($signed(resid));
    end else if (busy) begin
      if (!z[Z_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  // quadrant unfold into the held result
  always_ff @(posedge clk) begin
    if (fin) begin
      unique case (quad)
        2'd0: begin
          cos_q <= c_q;
          sin_q <= s_q;
        end
        2'd1: begin
          cos_q <= -s_q;
          sin_q <= c_q;
        end
        2'd2: begin
          cos_q <= -c_q;
          sin_q <= -s_q;
        end
        2'd3: begin
          cos_q <= s_q;
          sin_q <= -c_q;
        end
      endcase
    end
  end

endmodule

// ===== rtl/odo_mac.sv =====
// Shared 33x17 signed multiplier with a 64-bit weighted accumulator.
// Depends on odo_pkg (odo_mac_ctl_t, ROUND_HALF).
module odo_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  odo_pkg::odo_mac_ctl_t ctl,
  input  logic signed [32:0]   a,
  input  logic signed [16:0]   b,
  output logic [63:0]          acc
);
  import odo_pkg::*;

  logic signed [49:0] prod;
  odo_mac_ctl_t       prod_ctl;
  logic [63:0]        prod_ext;

  assign prod_ext = 64'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
    end else begin
      prod_ctl <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ctl.issue) begin
      if (prod_ctl.first) begin
        acc <= prod_ext + (prod_ctl.rnd ? ROUND_HALF : 64'd0);
      end else if (prod_ctl.shift32) begin
        acc <= acc + (prod_ext << 32);
      end else begin
        acc <= acc + (prod_ext << 16);
      end
    end
  end

endmodule

// ===== rtl/differential_odometry_integrator.sv =====
// Differential wheel odometry integrator: top level, sequencer and position state.
// Depends on odo_pkg, odo_cordic and odo_mac.
//
// Dead-reckoning integrator. A tick item converts both wheel positions
// (Q15.16 revolutions) to distances through dist_per_rev, takes the mean
// change since the previous tick and adds it, projected by cos and -sin of
// the heading, to the saturating X and Y positions; an axis step below
// step_deadband leaves that axis alone. Set and clear commands load or zero
// the position and keep the wheel distances. Every item gives one result
// transfer with the position and stored wheel distances after the item.
// A tick runs the CORDIC, one rotation per cycle, overlapped with the two
// wheel-distance products and followed by the two axis-step products; set
// and clear items go straight to the done step. All four products go
// through one 33x17 multiplier as two partial products each. in_stall is
// low only while the sequencer is idle; a finished result sits in the
// output register, so a new item can be taken while the previous result
// transfer is still stalled.
// Configuration writes take effect at once and belong in idle periods.
module differential_odometry_integrator #(
  parameter int POS_WIDTH       = 48,
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  odo_pkg::odo_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output odo_pkg::odo_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import odo_pkg::*;

  // saturation limits, carried in 64 bits
  localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] POS_MIN = -POS_MAX - 64'sd1;
  // width for position +/- a 48-bit step without overflow
  localparam int ACC_W = ((POS_WIDTH > 49) ? POS_WIDTH : 49) + 1;
  localparam logic signed [ACC_W-1:0] A_MAX = ACC_W'(POS_MAX);
  localparam logic signed [ACC_W-1:0] A_MIN = ACC_W'(POS_MIN);

  // configuration
  logic [31:0] dist_per_rev;
  logic [15:0] step_deadband;

  // odometry state
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] prev_l;
  logic signed [POS_WIDTH-1:0] prev_r;

  // per-item working registers
  odo_in_t                     in_q;
  logic signed [POS_WIDTH-1:0] dist_l;
  logic signed [POS_WIDTH-1:0] dist_r;
  logic [63:0]                 sum;
  logic [63:0]                 sum_mag;
  logic [14:0]                 mt_x;
  logic [14:0]                 mt_y;
  logic                        neg_x;
  logic                        neg_y;
  odo_out_t                    out_q;

  // sequencer
  odo_state_t state;
  odo_state_t state_next;
  odo_op_t    op;
  logic [1:0] phase;

  // datapath links
  odo_mac_ctl_t       mac_ctl;
  logic signed [32:0] mac_a;
  logic signed [16:0] mac_b;
  logic [63:0]        acc;
  odo_trig_t          trig;
  logic               trig_start;
  logic               in_xfer;
  logic               out_xfer;
  logic               out_load;

  logic [63:0]        sum_abs;
  logic signed [15:0] cos_neg;
  logic signed [15:0] sin_neg;
  logic [47:0]        step_mag;
  logic signed [POS_WIDTH-1:0] dist_new;

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [63:0] v);
    if (v > POS_MAX) begin
      return POS_MAX[POS_WIDTH-1:0];
    end else if (v < POS_MIN) begin
      return POS_MIN[POS_WIDTH-1:0];
    end
    return v[POS_WIDTH-1:0];
  endfunction

  // saturating add of a step magnitude, skipped inside the deadband
  function automatic logic signed [POS_WIDTH-1:0] apply_step(
    input logic signed [POS_WIDTH-1:0] pos,
    input logic [47:0]                 mag,
    input logic                        neg,
    input logic [15:0]                 band
  );
    logic signed [ACC_W-1:0] p;
    logic signed [ACC_W-1:0] m;
    logic signed [ACC_W-1:0] r;
    p = ACC_W'(pos);
    m = ACC_W'($signed({1'b0, mag}));
    r = neg ? (p - m) : (p + m);
    if (mag < {32'd0, band}) begin
      return pos;
    end else if (r > A_MAX) begin
      return POS_MAX[POS_WIDTH-1:0];
    end else if (r < A_MIN) begin
      return POS_MIN[POS_WIDTH-1:0];
    end
    return r[POS_WIDTH-1:0];
  endfunction

  function automatic logic signed [47:0] to_out(input logic signed [POS_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[47:0];
  endfunction

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_data = out_q;

  // operand shaping
  always_comb begin
    sum_abs  = sum[63] ? (64'd0 - sum) : sum;
    cos_neg  = -trig.cos_v;
    sin_neg  = -trig.sin_v;
    step_mag = acc[63:16];
    dist_new = sat_pos($signed(acc) >>> 16);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (in_data.cmd == CMD_TICK) ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        if (phase == 2'd2) begin
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        unique case (op)
          OP_LEFT:  state_next = S_MUL;
          OP_RIGHT: state_next = S_SUM;
          OP_Y:     state_next = S_MUL;
          OP_X:     state_next = S_DONE;
        endcase
      end
      S_SUM: state_next = S_ABS;
      S_ABS: begin
        if (trig.done) begin
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall        = (state != S_IDLE);
    trig_start      = (state == S_IDLE) && in_valid && (in_data.cmd == CMD_TICK);
    out_load        = (state == S_DONE) && (!out_valid || !out_stall);
    mac_ctl.issue   = (state == S_MUL) && (phase != 2'd2);
    mac_ctl.first   = (phase == 2'd0);
    mac_ctl.rnd     = (op == OP_Y) || (op == OP_X);
    mac_ctl.shift32 = (op == OP_Y) || (op == OP_X);
    unique case (op)
      OP_LEFT: begin
        mac_a = 33'(in_q.left_revs);
        mac_b = (phase == 2'd0) ? $signed({1'b0, dist_per_rev[15:0]})
                                : $signed({1'b0, dist_per_rev[31:16]});
      end
      OP_RIGHT: begin
        mac_a = 33'(in_q.right_revs);
        mac_b = (phase == 2'd0) ? $signed({1'b0, dist_per_rev[15:0]})
                                : $signed({1'b0, dist_per_rev[31:16]});
      end
      OP_Y: begin
        mac_a = (phase == 2'd0) ? $signed({1'b0, sum_mag[31:0]})
                                : $signed({1'b0, sum_mag[63:32]});
        mac_b = $signed({2'b00, mt_y});
      end
      OP_X: begin
        mac_a = (phase == 2'd0) ? $signed({1'b0, sum_mag[31:0]})
                                : $signed({1'b0, sum_mag[63:32]});
        mac_b = $signed({2'b00, mt_x});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_LEFT;
      phase <= 2'd0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          op    <= OP_LEFT;
          phase <= 2'd0;
        end
        S_MUL: phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
        S_TAKE: begin
          unique case (op)
            OP_LEFT:  op <= OP_RIGHT;
            OP_RIGHT: op <= OP_Y;
            OP_Y:     op <= OP_X;
            OP_X:     op <= OP_X;
          endcase
        end
        S_SUM, S_ABS, S_DONE: phase <= 2'd0;
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_rev  <= DIST_PER_REV_RST;
      step_deadband <= STEP_DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIST_PER_REV:  dist_per_rev  <= cfg_data;
        REG_STEP_DEADBAND: step_deadband <= cfg_data[15:0];
      endcase
    end
  end

  // odometry state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x  <= '0;
      pos_y  <= '0;
      prev_l <= '0;
      prev_r <= '0;
    end else begin
      if (in_xfer) begin
        unique case (in_data.cmd)
          CMD_TICK: ;
          CMD_SET: begin
            pos_x <= sat_pos(64'(in_data.new_x));
            pos_y <= sat_pos(64'(in_data.new_y));
          end
          CMD_CLR_X: pos_x <= '0;
          CMD_CLR_Y: pos_y <= '0;
        endcase
      end
      if (state == S_SUM) begin
        prev_l <= dist_l;
        prev_r <= dist_r;
      end
      if (state == S_TAKE && op == OP_Y) begin
        pos_y <= apply_step(pos_y, step_mag, neg_y, step_deadband);
      end
      if (state == S_TAKE && op == OP_X) begin
        pos_x <= apply_step(pos_x, step_mag, neg_x, step_deadband);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_q <= in_data;
    end
    if (state == S_TAKE && op == OP_LEFT) begin
      dist_l <= dist_new;
    end
    if (state == S_TAKE && op == OP_RIGHT) begin
      dist_r <= dist_new;
    end
    if (state == S_SUM) begin
      // wraps in 64 bits
      sum <= 64'(dist_l) - 64'(prev_l) + 64'(dist_r) - 64'(prev_r);
    end
    if (state == S_ABS) begin
      sum_mag <= sum_abs;
      mt_x    <= trig.cos_v[15] ? cos_neg[14:0] : trig.cos_v[14:0];
      mt_y    <= trig.sin_v[15] ? sin_neg[14:0] : trig.sin_v[14:0];
      // Y projects onto -sin
      neg_x   <= sum[63] ^ trig.cos_v[15];
      neg_y   <= sum[63] ^ (!trig.sin_v[15] && (trig.sin_v != 16'sd0));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q.pos_x          <= to_out(pos_x);
      out_q.pos_y          <= to_out(pos_y);
      out_q.left_distance  <= to_out(prev_l);
      out_q.right_distance <= to_out(prev_r);
    end
  end

  odo_cordic #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .heading (in_data.heading_angle),
    .trig    (trig)
  );

  odo_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  // a tick must invalidate the previous sine/cosine before the axis products
  a_trig_restart: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.cmd == CMD_TICK) |=> !trig.done)
    else $error("sine/cosine still flagged done after a new tick");

  a_clear_x: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.cmd == CMD_CLR_X) |=> (pos_x == '0))
    else $error("clear X did not zero the X position");

  a_prev_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_SUM) |=> ($stable(prev_l) && $stable(prev_r)))
    else $error("wheel distances changed outside the sum step");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result transfer raised outside the done step");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (phase != 2'd3))
    else $error("multiply phase out of range");

endmodule
